/* hw/rtl/pidc_pkg.sv */
// Shared types, constants and fixed-point helpers for the clamped PID controller.
// No dependencies; used by every module under hw/rtl.
package pidc_pkg;

  localparam int DATA_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int FRAC_SH   = 20;
  localparam int LIM_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int SAT_IN_W  = 2 * DATA_W + 1 - FRAC_SH;
  localparam int SUM_W     = DATA_W + 2;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM    = 3'd4;

  typedef struct packed {
    logic signed [DATA_W-1:0] err;
    logic signed [DIFF_W-1:0] diff;
  } pidc_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_prop;
    logic signed [DATA_W-1:0] gain_integ;
    logic signed [DATA_W-1:0] gain_deriv;
    logic        [LIM_W-1:0]  integral_limit;
    logic        [LIM_W-1:0]  output_limit;
  } pidc_cfg_t;

  // saturate a signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [DATA_W-1:0] res;
    if (v[SAT_IN_W-1:DATA_W-1] == {(SAT_IN_W-DATA_W+1){1'b0}} ||
        v[SAT_IN_W-1:DATA_W-1] == {(SAT_IN_W-DATA_W+1){1'b1}}) begin
      res = v[DATA_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return res;
  endfunction

  // symmetric clamp to +/- lim; a zero limit forces zero
  function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [SUM_W-1:0] v,
                                                         input logic [LIM_W-1:0] lim);
    logic signed [SUM_W-1:0]  lim_pos;
    logic signed [SUM_W-1:0]  lim_neg;
    logic signed [DATA_W-1:0] res;
    lim_pos = signed'({{(SUM_W-LIM_W){1'b0}}, lim});
    lim_neg = -lim_pos;
    if (v >= lim_pos) begin
      res = lim_pos[DATA_W-1:0];
    end else if (v <= lim_neg) begin
      res = lim_neg[DATA_W-1:0];
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/pidc_front.sv */
// Front end: accepts samples, forms the saturated error and the error change.
// Depends on pidc_pkg; feeds pidc_queue.
module pidc_front import pidc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,
  input  logic             q_full,
  output logic             q_push,
  output pidc_req_t        q_wdata
);

  logic signed [DATA_W-1:0]   prev_err_r;
  logic signed [DATA_W-1:0]   measured;
  logic signed [DATA_W-1:0]   setpoint;
  logic signed [DIFF_W-1:0]   raw_err;
  logic signed [DATA_W-1:0]   err;

  assign measured  = signed'(in_tdata[DATA_W-1:0]);
  assign setpoint  = signed'(in_tdata[2*DATA_W-1:DATA_W]);
  assign raw_err   = DIFF_W'(setpoint) - DIFF_W'(measured);
  assign err       = sat32(SAT_IN_W'(raw_err));

  assign in_tready    = !q_full;
  assign q_push       = in_tvalid && in_tready;
  assign q_wdata.err  = err;
  assign q_wdata.diff = DIFF_W'(err) - DIFF_W'(prev_err_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (q_push) begin
      prev_err_r <= err;
    end
  end

endmodule

/* hw/rtl/pidc_queue.sv */
// Short request queue between front and back end.
// Depends on pidc_pkg.
module pidc_queue import pidc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pidc_req_t wdata,
  output logic      full,
  input  logic      pop,
  output logic      rvalid,
  output pidc_req_t rdata
);

  pidc_req_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               do_pop;

  assign full   = (count_r == QCNT_W'(QDEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];
  assign do_pop = pop && rvalid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/pidc_back.sv */
// Back end: gain products, integral update, sum and clamp, output register.
// Depends on pidc_pkg; drains pidc_queue.
module pidc_back import pidc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pidc_cfg_t         cfg,
  input  logic              q_rvalid,
  input  pidc_req_t         q_rdata,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata
);

  logic                        adv;
  logic                        s1_v_r;
  logic                        s2_v_r;
  logic                        s3_v_r;
  logic                        out_v_r;
  logic signed [2*DATA_W-1:0]  prod_p_r;
  logic signed [2*DATA_W-1:0]  prod_i_r;
  logic signed [2*DATA_W:0]    prod_d_r;
  logic signed [DATA_W-1:0]    p_term_r;
  logic signed [DATA_W-1:0]    i_term_r;
  logic signed [DATA_W-1:0]    d_term_r;
  logic signed [DATA_W-1:0]    acc_r;
  logic signed [DATA_W-1:0]    acc_nxt;
  logic signed [DATA_W:0]      pd_r;
  logic signed [DATA_W-1:0]    out_data_r;
  logic signed [DATA_W-1:0]    drive_nxt;

  assign adv        = !out_v_r || out_tready;
  assign q_pop      = adv && q_rvalid;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  assign acc_nxt   = clamp_sym(SUM_W'(acc_r) + SUM_W'(i_term_r), cfg.integral_limit);
  assign drive_nxt = clamp_sym(SUM_W'(pd_r) + SUM_W'(acc_r), cfg.output_limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      acc_r   <= '0;
    end else if (adv) begin
      s1_v_r  <= q_rvalid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
      if (s2_v_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_p_r   <= q_rdata.err * cfg.gain_prop;
      prod_i_r   <= q_rdata.err * cfg.gain_integ;
      prod_d_r   <= q_rdata.diff * cfg.gain_deriv;
      p_term_r   <= sat32(SAT_IN_W'(signed'(prod_p_r[2*DATA_W-1:FRAC_SH])));
      i_term_r   <= sat32(SAT_IN_W'(signed'(prod_i_r[2*DATA_W-1:FRAC_SH])));
      d_term_r   <= sat32(prod_d_r[2*DATA_W:FRAC_SH]);
      pd_r       <= (DATA_W+1)'(p_term_r) + (DATA_W+1)'(d_term_r);
      out_data_r <= drive_nxt;
    end
  end

endmodule

/* hw/rtl/pid_controller_clamped.sv */
// Top level of the clamped positional PID controller: register file and wiring.
// Depends on pidc_pkg, pidc_front, pidc_queue and pidc_back.
//
// One sample (measured, setpoint) in, one clamped drive value out. A new sample is
// accepted every clock cycle while the queue is not full; a sample's drive passes
// through the queue slot (written at the accepting edge), then the product stage,
// term stage, integral stage and output register. A two-entry queue sits between the
// error front end and the arithmetic back end, so up to two further samples are
// accepted while a result waits; a stalled output holds the whole back end. Gains and
// limits reset to zero; the user must write them only while the controller is idle,
// which the block itself does not enforce. Writes to unknown indexes are dropped.
module pid_controller_clamped import pidc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // [31:0] measured, [63:32] setpoint
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [31:0] drive
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  pidc_cfg_t cfg_r;
  pidc_req_t q_wdata;
  pidc_req_t q_rdata;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_rvalid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_PROP:  cfg_r.gain_prop      <= signed'(cfg_data);
        REG_GAIN_INTEG: cfg_r.gain_integ     <= signed'(cfg_data);
        REG_GAIN_DERIV: cfg_r.gain_deriv     <= signed'(cfg_data);
        REG_INTEG_LIM:  cfg_r.integral_limit <= cfg_data[LIM_W-1:0];
        REG_OUT_LIM:    cfg_r.output_limit   <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  pidc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  pidc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_rvalid),
    .rdata  (q_rdata)
  );

  pidc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_rvalid   (q_rvalid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
